>>> hdl/slab_pkg.sv
// ----------------------------------------------------------------------------
// slab_pkg
// Constants, lookup tables and table builders for the sRGB to CIELAB pipe.
// ----------------------------------------------------------------------------
package slab_pkg;

   typedef logic [15:0] lin_tab_type  [256];
   typedef logic [16:0] cube_tab_type [257];
   typedef logic [15:0] mtx_type      [3][3];

   localparam int unsigned LinKneeCode = 10;
   localparam longint unsigned LinSegDen = 64'd329460;
   localparam longint unsigned LinPowDen = 64'd269025;

   localparam mtx_type MTX = '{
      '{16'd28439, 16'd24655, 16'd12441},
      '{16'd13938, 16'd46868, 16'd4730},
      '{16'd1164,  16'd7174,  16'd57198}
   };

   localparam logic [15:0] F_KNEE      = 16'd580;
   localparam logic [25:0] F_SEG_MUL   = 26'd24389;
   localparam logic [25:0] F_SEG_ADD   = 26'd28313118;
   localparam longint unsigned FSegDen = 64'd3132;
   localparam logic [20:0] F_SEG_RECIP = 21'((64'd1 << 32) / FSegDen);
   localparam logic [25:0] F_SEG_DIV   = 26'(FSegDen);

   // (a*b) >> 60
   function automatic logic [63:0] mul60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      begin
         p = {64'd0, a} * {64'd0, b};
         return p[123:60];
      end
   endfunction

   function automatic logic [15:0] lin_value(input int unsigned code);
      logic [63:0] n, q, r, x, x2, x3, x6, x12, lo, hi, mid, yq, p;
      begin
         if (code <= LinKneeCode) begin
            return 16'((64'(code) * 64'd6553600 + 64'd164730) / LinSegDen);
         end
         n   = 64'(code) * 64'd1000 + 64'd14025;
         q   = (n << 40) / LinPowDen;
         r   = (n << 40) % LinPowDen;
         x   = (q << 20) + ((r << 20) / LinPowDen);
         x2  = mul60(x, x);
         x3  = mul60(x2, x);
         x6  = mul60(x3, x3);
         x12 = mul60(x6, x6);
         lo  = 64'd0;
         hi  = 64'd65535;
         for (int k = 0; k < 18; k++) begin
            if (lo < hi) begin
               mid = (lo + hi + 64'd1) >> 1;
               yq  = mid << 44;
               p   = mul60(yq, yq);
               p   = mul60(p, p);
               p   = mul60(p, yq);
               if (p <= x12) lo = mid;
               else          hi = mid - 64'd1;
            end
         end
         return lo[15:0];
      end
   endfunction

   function automatic lin_tab_type build_lin();
      lin_tab_type t;
      begin
         for (int unsigned i = 0; i < 256; i++) t[i] = lin_value(i);
         return t;
      end
   endfunction

   function automatic logic [16:0] cube_value(input int unsigned i);
      logic [63:0] v, lo, hi, mid;
      begin
         v  = 64'(i) << 40;
         lo = 64'd0;
         hi = 64'd65536;
         for (int k = 0; k < 19; k++) begin
            if (lo < hi) begin
               mid = (lo + hi + 64'd1) >> 1;
               if (mid * mid * mid <= v) lo = mid;
               else                      hi = mid - 64'd1;
            end
         end
         return lo[16:0];
      end
   endfunction

   function automatic cube_tab_type build_cube();
      cube_tab_type t;
      begin
         for (int unsigned i = 0; i < 257; i++) t[i] = cube_value(i);
         return t;
      end
   endfunction

   localparam lin_tab_type  LIN_TAB  = build_lin();
   localparam cube_tab_type CUBE_TAB = build_cube();

endpackage

>>> hdl/slab_xyz.sv
// ----------------------------------------------------------------------------
// slab_xyz
// Linearizes the three codes by table and applies the white-normalized
// RGB-to-XYZ matrix. Three register stages.
// ----------------------------------------------------------------------------
module slab_xyz
   import slab_pkg::*;
(
   input  logic             clock,
   input  logic [7:0]       red_code,
   input  logic [7:0]       green_code,
   input  logic [7:0]       blue_code,
   output logic [2:0][15:0] t_out
);

   logic [2:0][15:0]      lin_ff;
   logic [2:0][2:0][31:0] prod_ff, prod_in;
   logic [2:0][15:0]      t_ff, t_in;
   logic [33:0]           sum;

   always_ff @(posedge clock) begin
      lin_ff[0] <= LIN_TAB[red_code];
      lin_ff[1] <= LIN_TAB[green_code];
      lin_ff[2] <= LIN_TAB[blue_code];
      prod_ff   <= prod_in;
      t_ff      <= t_in;
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = 32'(MTX[r][c]) * 32'(lin_ff[c]);
         end
      end
   end

   always_comb begin
      sum = '0;
      for (int r = 0; r < 3; r++) begin
         sum = 34'(prod_ff[r][0]) + 34'(prod_ff[r][1]) + 34'(prod_ff[r][2]) + 34'd32768;
         if (sum[33:32] != 2'd0) t_in[r] = 16'hFFFF;
         else                    t_in[r] = sum[31:16];
      end
   end

   assign t_out = t_ff;

endmodule

>>> hdl/slab_f.sv
// ----------------------------------------------------------------------------
// slab_f
// CIELAB f function for one channel: linear segment below the knee,
// interpolated cube-root table above it. Three register stages.
// ----------------------------------------------------------------------------
module slab_f
   import slab_pkg::*;
(
   input  logic        clock,
   input  logic [15:0] t_val,
   output logic [16:0] f_val
);

   // stage 1
   logic        knee1_ff;
   logic [25:0] v1_ff;
   logic [16:0] e0_ff;
   logic [16:0] diff_ff;
   logic [7:0]  frac_ff;
   // stage 2
   logic        knee2_ff;
   logic [25:0] v2_ff;
   logic [46:0] kp_ff, kp_in;
   logic [16:0] ip_ff, ip_in;
   // stage 3
   logic [16:0] f_ff, f_in;

   logic [8:0]  idx_p0;
   logic [8:0]  idx_p1;
   logic [25:0] cnt_in;
   logic [14:0] q0;
   logic [25:0] rem;

   assign idx_p0 = {1'b0, t_val[15:8]};
   assign idx_p1 = idx_p0 + 9'd1;
   assign cnt_in = 26'(t_val) * F_SEG_MUL + F_SEG_ADD;

   always_ff @(posedge clock) begin
      knee1_ff <= (t_val <= F_KNEE);
      v1_ff    <= cnt_in;
      e0_ff    <= CUBE_TAB[idx_p0];
      diff_ff  <= CUBE_TAB[idx_p1] - CUBE_TAB[idx_p0];
      frac_ff  <= t_val[7:0];
      knee2_ff <= knee1_ff;
      v2_ff    <= v1_ff;
      kp_ff    <= kp_in;
      ip_ff    <= ip_in;
      f_ff     <= f_in;
   end

   logic [25:0] ip_prod;

   always_comb begin
      kp_in   = 47'(v1_ff) * 47'(F_SEG_RECIP);
      ip_prod = 26'(diff_ff) * 26'(frac_ff) + 26'd128;
      ip_in   = e0_ff + 17'(ip_prod[25:8]);
   end

   always_comb begin
      q0  = kp_ff[46:32];
      rem = v2_ff - 26'(q0) * F_SEG_DIV;
      if (knee2_ff) begin
         if (rem >= F_SEG_DIV) f_in = 17'(q0) + 17'd1;
         else                  f_in = 17'(q0);
      end else begin
         f_in = ip_ff;
      end
   end

   assign f_val = f_ff;

endmodule

>>> hdl/srgb_to_cielab.sv
// ----------------------------------------------------------------------------
// srgb_to_cielab
// sRGB (8-bit codes) to CIELAB D65, L/a/b scaled by 256.
//
// Usage:
//   Drive req_red_code/req_green_code/req_blue_code and raise start. A
//   transaction is taken at each rising edge with start high and busy low;
//   busy is always low, so one pixel may enter every cycle.
//   For each accepted pixel, the result shows on
//   rsp_lightness/rsp_chroma_a/rsp_chroma_b with rsp_valid high for exactly
//   one cycle. Throughput is one pixel per cycle, set by a fully pipelined
//   datapath: 3 stages for table linearization and the XYZ matrix, 3 for
//   the f function (reciprocal divide / cube-root interpolation), 1 for the
//   L/a/b scaling and saturation.
//   The receiver cannot stall; results are presented once and not held.
//   Synchronous reset clears the valid pipeline; transactions in flight are
//   dropped and no result appears until a new one is accepted.
// ----------------------------------------------------------------------------
module srgb_to_cielab
   import slab_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_red_code,
   input  logic [7:0]         req_green_code,
   input  logic [7:0]         req_blue_code,
   output logic               rsp_valid,
   output logic [14:0]        rsp_lightness,
   output logic signed [15:0] rsp_chroma_a,
   output logic signed [15:0] rsp_chroma_b
);

   localparam int Latency = 7;

   logic [Latency-1:0] vld_ff, vld_in;
   logic [2:0][15:0]   t_val;
   logic [2:0][16:0]   f_val;

   logic [14:0]        l_ff, l_in;
   logic signed [15:0] a_ff, a_in;
   logic signed [15:0] b_ff, b_in;

   assign busy = 1'b0;

   slab_xyz u_xyz (
      .clock      (clock),
      .red_code   (req_red_code),
      .green_code (req_green_code),
      .blue_code  (req_blue_code),
      .t_out      (t_val)
   );

   for (genvar g = 0; g < 3; g++) begin : g_f
      slab_f u_f (
         .clock (clock),
         .t_val (t_val[g]),
         .f_val (f_val[g])
      );
   end

   assign vld_in = {vld_ff[Latency-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff <= l_in;
      a_ff <= a_in;
      b_ff <= b_in;
   end

   function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
      logic signed [27:0] s;
      begin
         s = (v + 28'sd128) >>> 8;
         if (s > 28'sd32767)       return 16'sh7FFF;
         else if (s < -28'sd32768) return 16'sh8000;
         else                      return s[15:0];
      end
   endfunction

   logic [23:0]        ly;
   logic signed [17:0] la;
   logic signed [17:0] dxa, dyb;

   always_comb begin
      ly  = 24'(f_val[1]) * 24'd116 + 24'd128;
      la  = $signed({2'b00, ly[23:8]}) - 18'sd4096;
      if (la < 18'sd0)          l_in = 15'd0;
      else if (la > 18'sd32767) l_in = 15'h7FFF;
      else                      l_in = la[14:0];
      dxa  = $signed({1'b0, f_val[0]}) - $signed({1'b0, f_val[1]});
      dyb  = $signed({1'b0, f_val[1]}) - $signed({1'b0, f_val[2]});
      a_in = sat16(28'(dxa) * 28'sd500);
      b_in = sat16(28'(dyb) * 28'sd200);
   end

   assign rsp_valid     = vld_ff[Latency-1];
   assign rsp_lightness = l_ff;
   assign rsp_chroma_a  = a_ff;
   assign rsp_chroma_b  = b_ff;

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for srgb_to_cielab: directed and random sRGB pixels are
// driven with random gaps, L/a/b results are predicted in a scoreboard and
// compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   class lab_scoreboard;
      logic [15:0] lin_lut [256];
      logic [16:0] cbrt_lut [257];
      logic [46:0] pending [$];
      int errors;

      function logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
         logic [127:0] p;
         p = {64'd0, a} * {64'd0, b};
         return p[123:60];
      endfunction

      function logic [15:0] gamma_expand(int code);
         logic [63:0] n, x, x12, lo, hi, mid, yq, p;
         if (code <= 10) return 16'((64'(code) * 6553600 + 164730) / 329460);
         n = 64'(code) * 1000 + 14025;
         x = (((n << 40) / 269025) << 20) + ((((n << 40) % 269025) << 20) / 269025);
         x12 = q60_mul(x, x);
         x12 = q60_mul(x12, x);
         x12 = q60_mul(x12, x12);
         x12 = q60_mul(x12, x12);
         lo = 0;
         hi = 65535;
         while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            yq = mid << 44;
            p = q60_mul(yq, yq);
            p = q60_mul(p, p);
            p = q60_mul(p, yq);
            if (p <= x12) lo = mid;
            else hi = mid - 1;
         end
         return lo[15:0];
      endfunction

      function logic [16:0] cube_root_q16(int i);
         logic [63:0] v, lo, hi, mid;
         v = 64'(i) << 40;
         lo = 0;
         hi = 65536;
         while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid * mid <= v) lo = mid;
            else hi = mid - 1;
         end
         return lo[16:0];
      endfunction

      function new();
         for (int i = 0; i < 256; i++) lin_lut[i] = gamma_expand(i);
         for (int i = 0; i < 257; i++) cbrt_lut[i] = cube_root_q16(i);
         errors = 0;
      endfunction

      function longint lab_f(longint t);
         longint e0, e1, fr;
         if (t <= 580) return (t * 24389 + 28313118) / 3132;
         e0 = cbrt_lut[t >> 8];
         e1 = cbrt_lut[(t >> 8) + 1];
         fr = t & 255;
         return e0 + (((e1 - e0) * fr + 128) >>> 8);
      endfunction

      function logic [15:0] round_sat(longint v);
         longint s;
         s = (v + 128) >>> 8;
         if (s > 32767) s = 32767;
         if (s < -32768) s = -32768;
         return s[15:0];
      endfunction

      function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         longint lin [3], f [3], acc, l;
         lin[0] = lin_lut[r];
         lin[1] = lin_lut[g];
         lin[2] = lin_lut[b];
         for (int row = 0; row < 3; row++) begin
            acc = 32768;
            for (int c = 0; c < 3; c++) acc += longint'(slab_pkg::MTX[row][c]) * lin[c];
            acc = acc >> 16;
            if (acc > 65535) acc = 65535;
            f[row] = lab_f(acc);
         end
         l = ((116 * f[1] + 128) >>> 8) - 4096;
         if (l < 0) l = 0;
         pending.push_back({l[14:0], round_sat(500 * (f[0] - f[1])),
                            round_sat(200 * (f[1] - f[2]))});
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
         errors++;
      endtask

      task check_result(logic [14:0] l, logic signed [15:0] a, logic signed [15:0] b);
         logic [46:0] e;
         if (pending.size() == 0) begin
            report("unexpected transaction", 0, 0);
            return;
         end
         e = pending.pop_front();
         if (l !== e[46:32]) report("lightness", l, e[46:32]);
         if (a !== e[31:16]) report("chroma_a", a, $signed(e[31:16]));
         if (b !== e[15:0]) report("chroma_b", b, $signed(e[15:0]));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [7:0] req_red_code = 0, req_green_code = 0, req_blue_code = 0;
   logic rsp_valid;
   logic [14:0] rsp_lightness;
   logic signed [15:0] rsp_chroma_a, rsp_chroma_b;
   lab_scoreboard sb = new();
   int idle_cycles = 0;
   int burst_mode = 0;

   always #1 clock = ~clock;

   srgb_to_cielab dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_red_code(req_red_code), .req_green_code(req_green_code),
      .req_blue_code(req_blue_code), .rsp_valid(rsp_valid),
      .rsp_lightness(rsp_lightness), .rsp_chroma_a(rsp_chroma_a),
      .rsp_chroma_b(rsp_chroma_b)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_lightness, rsp_chroma_a, rsp_chroma_b);
      if ((start && !busy) || rsp_valid || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("srgb_to_cielab regression: fail");
         $finish;
      end
   end

   task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int gap, sel;
      sel = $urandom_range(0, 99);
      if (burst_mode) gap = 0;
      else if (sel < 55) gap = 0;
      else if (sel < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_red_code <= r;
      req_green_code <= g;
      req_blue_code <= b;
      forever begin
         @(negedge clock);
         if (!busy) begin
            @(posedge clock);
            sb.note_pixel(r, g, b);
            break;
         end
         @(posedge clock);
      end
   endtask

   function logic [7:0] pick_code();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 8'(($urandom_range(0, 1)) ? 255 : 0);
      if (sel == 1) return 8'($urandom_range(8, 13));
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      logic [7:0] dir [20][3] = '{
         '{0, 0, 0}, '{255, 255, 255}, '{255, 0, 0}, '{0, 255, 0}, '{0, 0, 255},
         '{255, 255, 0}, '{255, 0, 255}, '{0, 255, 255}, '{10, 10, 10},
         '{11, 11, 11}, '{1, 1, 1}, '{128, 128, 128}, '{10, 11, 12},
         '{0, 0, 1}, '{254, 254, 254}, '{255, 0, 128}, '{0, 255, 255},
         '{170, 85, 51}, '{2, 0, 9}, '{0, 128, 255}};
      repeat (9) @(posedge clock);
      reset <= 0;
      foreach (dir[i]) send_pixel(dir[i][0], dir[i][1], dir[i][2]);
      for (int i = 0; i < 1200; i++) begin
         if (i % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         send_pixel(pick_code(), pick_code(), pick_code());
      end
      start <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) $display("srgb_to_cielab regression: pass");
      else $display("srgb_to_cielab regression: fail");
      $finish;
   end
endmodule
